### design/nnr_pkg.sv
// Shared types, constants and helpers of the nearest-neighbor resampler.
// Used by nnr_ctrl, nnr_datapath and the top level; no dependencies of its own.
`default_nettype none

package nnr_pkg;

    // Default widths handed down from the top level
    localparam int LENGTH_BITS_DEF = 20;
    localparam int SAMPLE_BITS_DEF = 8;

    // Rate registers and their legal range
    localparam int            RATE_BITS = 16;
    localparam logic [15:0]   RATE_MIN  = 16'd2000;
    localparam logic [15:0]   RATE_MAX  = 16'd50000;
    localparam logic [15:0]   RATE_RESET = 16'd8000;

    // Most results one source pair may produce
    localparam int MAX_RESULTS = 27;

    // Configuration register indexes
    localparam int          CFG_ADDR_BITS     = 2;
    localparam logic [1:0]  CFG_SOURCE_LENGTH = 2'd0;
    localparam logic [1:0]  CFG_SOURCE_RATE   = 2'd1;
    localparam logic [1:0]  CFG_TARGET_RATE   = 2'd2;
    localparam logic [1:0]  CFG_STEREO_MODE   = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch an input transaction
        logic mul;         // form target_rate * source_length
        logic div_start;   // launch the divider
        logic set_target;  // load the new target length
        logic emit;        // load one result into the output register
        logic finish;      // advance the source pair count
    } nnr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic new_sound;   // next pair is the first of a sound
        logic div_done;    // divider quotient valid
        logic more_now;    // a result is due for the current pair
        logic more_after;  // another result follows the one due now
        logic out_free;    // output register can take a result
    } nnr_status_t;

    // Clamp a rate into the legal range
    function automatic logic [RATE_BITS-1:0] clamp_rate(input logic [RATE_BITS-1:0] r);
        logic [RATE_BITS-1:0] c;
        c = r;
        if (r < RATE_MIN) c = RATE_MIN;
        if (r > RATE_MAX) c = RATE_MAX;
        return c;
    endfunction

endpackage

`default_nettype wire

### design/nnr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module nnr_div #(
    parameter int NUM_BITS = 36,
    parameter int DEN_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    // Shift in the next numerator bit and try the subtraction
    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control: count the quotient bits, pulse done at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

### design/nnr_datapath.sv
// Datapath of the resampler: configuration registers, sound counters,
// target length arithmetic and the output register. Uses nnr_pkg and nnr_div.
`default_nettype none

module nnr_datapath #(
    parameter int LENGTH_BITS = nnr_pkg::LENGTH_BITS_DEF,
    parameter int SAMPLE_BITS = nnr_pkg::SAMPLE_BITS_DEF,
    parameter int CFG_BITS    = nnr_pkg::LENGTH_BITS_DEF,
    parameter int DATA_BITS   = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wen,
    input  wire logic [nnr_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_BITS-1:0]               cfg_wdata,
    // input payload
    input  wire logic [DATA_BITS-1:0]              s_tdata,
    // controller link
    input  wire nnr_pkg::nnr_cmd_t                 cmd,
    output nnr_pkg::nnr_status_t                   status,
    // result channel
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [DATA_BITS-1:0]                   m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser
);

    localparam int ACC_BITS   = 2 * LENGTH_BITS;
    localparam int PROD_BITS  = nnr_pkg::RATE_BITS + LENGTH_BITS;
    localparam int BURST_BITS = $clog2(nnr_pkg::MAX_RESULTS + 1);

    // Configuration registers
    logic [LENGTH_BITS-1:0]        src_len_reg;
    logic [nnr_pkg::RATE_BITS-1:0] src_rate_reg;
    logic [nnr_pkg::RATE_BITS-1:0] tgt_rate_reg;
    logic                          stereo_reg;

    // Sound state
    logic [LENGTH_BITS-1:0] src_count_reg;
    logic [LENGTH_BITS-1:0] out_count_reg;
    logic [LENGTH_BITS-1:0] target_len_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic [ACC_BITS-1:0]    limit_reg;
    logic [BURST_BITS-1:0]  burst_reg;

    // Held input pair and product
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    // Output register
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] out_left_reg;
    logic [SAMPLE_BITS-1:0] out_right_reg;
    logic                   out_run_last_reg;
    logic                   out_sound_last_reg;

    logic                   restart;
    logic [PROD_BITS-1:0]   quot;
    logic                   div_done;
    logic [LENGTH_BITS-1:0] target_next;
    logic [LENGTH_BITS-1:0] src_count_inc;
    logic [LENGTH_BITS-1:0] src_count_next;
    logic [LENGTH_BITS:0]   out_count_inc;
    logic [ACC_BITS-1:0]    acc_next;
    logic [BURST_BITS-1:0]  burst_inc;
    logic                   sound_last;

    // Every write to a register returns the stream to the start of a sound
    assign restart = cfg_wen;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_len_reg  <= LENGTH_BITS'(1);
            src_rate_reg <= nnr_pkg::RATE_RESET;
            tgt_rate_reg <= nnr_pkg::RATE_RESET;
            stereo_reg   <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                nnr_pkg::CFG_SOURCE_LENGTH: src_len_reg  <= cfg_wdata[LENGTH_BITS-1:0];
                nnr_pkg::CFG_SOURCE_RATE:   src_rate_reg <= cfg_wdata[nnr_pkg::RATE_BITS-1:0];
                nnr_pkg::CFG_TARGET_RATE:   tgt_rate_reg <= cfg_wdata[nnr_pkg::RATE_BITS-1:0];
                nnr_pkg::CFG_STEREO_MODE:   stereo_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Latch the pair; mono copies left into right
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            left_reg  <= s_tdata[SAMPLE_BITS-1:0];
            right_reg <= stereo_reg ? s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]
                                    : s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Target rate times source length, registered before the divider
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= PROD_BITS'(nnr_pkg::clamp_rate(tgt_rate_reg))
                      * PROD_BITS'(src_len_reg);
        end
    end

    nnr_div #(
        .NUM_BITS (PROD_BITS),
        .DEN_BITS (nnr_pkg::RATE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (prod_reg),
        .den     (nnr_pkg::clamp_rate(src_rate_reg)),
        .done    (div_done),
        .quot    (quot)
    );

    // Saturate the quotient to the length range, then round down to even
    always_comb begin
        if (quot[PROD_BITS-1:LENGTH_BITS] != '0) begin
            target_next = {{(LENGTH_BITS-1){1'b1}}, 1'b0};
        end else begin
            target_next = {quot[LENGTH_BITS-1:1], 1'b0};
        end
    end

    // Next values of the counters
    assign src_count_inc  = src_count_reg + LENGTH_BITS'(1);
    assign src_count_next = (src_count_inc >= src_len_reg) ? '0 : src_count_inc;
    assign out_count_inc  = {1'b0, out_count_reg} + (LENGTH_BITS+1)'(1);
    assign acc_next       = acc_reg + ACC_BITS'(src_len_reg);
    assign burst_inc      = burst_reg + BURST_BITS'(1);
    assign sound_last     = (out_count_inc == {1'b0, target_len_reg});

    // Sound counters, accumulator and output limit
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            src_count_reg  <= '0;
            out_count_reg  <= '0;
            target_len_reg <= '0;
            acc_reg        <= '0;
            limit_reg      <= '0;
            burst_reg      <= '0;
        end else begin
            if (cmd.accept) begin
                burst_reg <= '0;
                // a continuing sound extends the limit by one target length
                if (src_count_reg != '0) begin
                    limit_reg <= limit_reg + ACC_BITS'(target_len_reg);
                end
            end
            if (cmd.set_target) begin
                target_len_reg <= target_next;
                limit_reg      <= ACC_BITS'(target_next);
                out_count_reg  <= '0;
                acc_reg        <= '0;
            end
            if (cmd.emit) begin
                out_count_reg <= out_count_inc[LENGTH_BITS-1:0];
                acc_reg       <= acc_next;
                burst_reg     <= burst_inc;
            end
            if (cmd.finish) begin
                src_count_reg <= src_count_next;
            end
        end
    end

    // Output register: hold until the receiver takes the transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_left_reg       <= left_reg;
            out_right_reg      <= right_reg;
            out_run_last_reg   <= ~status.more_after;
            out_sound_last_reg <= sound_last;
        end
    end

    // Status back to the controller
    always_comb begin
        status.new_sound  = (src_count_reg == '0);
        status.div_done   = div_done;
        status.more_now   = (out_count_reg < target_len_reg) && (acc_reg < limit_reg)
                          && (burst_reg < BURST_BITS'(nnr_pkg::MAX_RESULTS));
        status.more_after = (out_count_inc < {1'b0, target_len_reg}) && (acc_next < limit_reg)
                          && (burst_inc < BURST_BITS'(nnr_pkg::MAX_RESULTS));
        status.out_free   = ~m_valid_reg | m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_BITS'({out_right_reg, out_left_reg});
    assign m_tlast  = out_run_last_reg;
    assign m_tuser  = out_sound_last_reg;

endmodule

`default_nettype wire

### design/nnr_ctrl.sv
// Controller of the resampler: sequences accept, target length division
// and the result burst of each source pair. Uses nnr_pkg types.
`default_nettype none

module nnr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire nnr_pkg::nnr_status_t status,
    output nnr_pkg::nnr_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DSTART = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.new_sound ? ST_MUL : ST_EMIT;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.set_target = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // drop out at once when the pair produces nothing more
                if (!status.more_now) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (!status.more_after) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/nearest_neighbor_resampler_core.sv
// Nearest-neighbor audio resampler, top level.
// Uses nnr_pkg, nnr_ctrl, nnr_datapath (which holds nnr_div).
//
// Usage: write source_length, source_rate, target_rate and stereo_mode on the
// cfg_* port while the block is idle; any write restarts the sound. Then
// stream the source sound, one left/right pair per s_axis transaction. Each
// pair produces zero or more m_axis transactions carrying the nearest source
// pair; m_axis_tlast marks the last result of a pair, m_axis_tuser the final
// sample of the whole output sound.
// Timing: one pair is in work at a time. The first pair of a sound passes
// through accept, the multiply and the bit-serial divide that yields the
// target length, then emits its results; every later pair goes from
// accept straight to its results.
// Results sit in an output register: the next pair is accepted while the
// last result still waits; a stalled receiver holds the burst in place.
// Reset returns the registers to source_length 1, both rates 8000 and mono,
// and clears all counters.
`default_nettype none

module nearest_neighbor_resampler_core #(
    parameter  int LENGTH_BITS = nnr_pkg::LENGTH_BITS_DEF,
    parameter  int SAMPLE_BITS = nnr_pkg::SAMPLE_BITS_DEF,
    localparam int CFG_BITS    = (LENGTH_BITS > nnr_pkg::RATE_BITS) ? LENGTH_BITS
                                                                     : nnr_pkg::RATE_BITS,
    localparam int DATA_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wen,
    input  wire logic [nnr_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_BITS-1:0]               cfg_wdata,
    // source pairs
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [DATA_BITS-1:0]              s_axis_tdata,  // left_sample, right_sample
    // resampled pairs
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [DATA_BITS-1:0]                   m_axis_tdata,  // left_out, right_out
    output logic                                   m_axis_tlast,  // run_last
    output logic                                   m_axis_tuser   // sound_last
);

    nnr_pkg::nnr_cmd_t    cmd;
    nnr_pkg::nnr_status_t status;

    nnr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nnr_datapath #(
        .LENGTH_BITS (LENGTH_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CFG_BITS    (CFG_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast),
        .m_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire
